### rtl/core/hpt_pkg.sv
// hpt_pkg: shared constants, item types and internal unit interfaces
// for the homogeneous point transform; no dependencies
`timescale 1ns / 1ps

package hpt_pkg;

   localparam int WORD_BITS     = 32;
   localparam int FRACTION_BITS = 16;
   localparam int MAT_ENTRIES   = 16;
   localparam int MAT_IDX_BITS  = $clog2(MAT_ENTRIES);
   localparam int ACC_BITS      = 2 * WORD_BITS + 2;
   localparam int QUO_BITS      = WORD_BITS + FRACTION_BITS;
   localparam int QCNT_BITS     = $clog2(QUO_BITS);

   typedef logic [1:0] cmd_type;
   localparam cmd_type CMD_LOAD   = 2'd0;
   localparam cmd_type CMD_VECTOR = 2'd1;
   localparam cmd_type CMD_POINT  = 2'd2;

   typedef logic signed [WORD_BITS-1:0] word_type;

   localparam word_type WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam word_type WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
   localparam word_type FIX_ONE  =
      {{(WORD_BITS-FRACTION_BITS-1){1'b0}}, 1'b1, {FRACTION_BITS{1'b0}}};

   typedef struct packed {
      cmd_type                 cmd;
      logic [MAT_IDX_BITS-1:0] entry_index;
      word_type                entry_value;
      word_type                in_x;
      word_type                in_y;
      word_type                in_z;
      word_type                in_w;
   } req_type;

   typedef struct packed {
      word_type out_x;
      word_type out_y;
      word_type out_z;
      word_type out_w;
      logic     zero_divisor;
      logic     overflow;
   } rsp_type;

   typedef struct packed {
      logic     issue;
      logic     first;
      word_type a;
      word_type b;
   } mac_req_type;

   typedef struct packed {
      logic     start;
      word_type num;
      word_type den;
   } div_req_type;

   typedef struct packed {
      logic     done;
      word_type quotient;
      logic     overflow;
   } div_rsp_type;

endpackage

### rtl/core/homogeneous_point_transform.sv
// homogeneous_point_transform: top level, 4x4 matrix store and sequencer
// around the shared multiply-accumulate unit and the serial divider
// depends on hpt_pkg, hpt_mac, hpt_div
//
// usage
//   req channel (req_valid/req_stall/req_data): one item per command.
//   a load item writes one matrix entry (index 4*column+row) and gives no
//   result. cmd 3 is dropped without effect.
//   a vector item returns M*(x,y,z,w); a point item uses w = 1.0, divides
//   rows 0..2 by row 3 and returns the quotients plus the undivided row 3.
//   rsp channel (rsp_valid/rsp_stall/rsp_data): one result per vector or
//   point item, held in an output register until taken.
// datapath
//   the 16 products go through one multiplier, one per cycle. a point item
//   adds three divisions (none when row 3 is zero) on one restoring divider
//   at one quotient bit per cycle, 48 bits each. req_stall is high for the
//   whole time an item is in work.
// reset: synchronous, restores the identity matrix and empties the output.
// a stalled rsp keeps its item; a finished item waits for the register.
`timescale 1ns / 1ps

module homogeneous_point_transform (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  hpt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output hpt_pkg::rsp_type rsp_data
);

   localparam int W = hpt_pkg::WORD_BITS;
   localparam int F = hpt_pkg::FRACTION_BITS;
   localparam logic [4:0] STEP_FIRST_SAVE = 5'd5;
   localparam logic [4:0] STEP_LAST       = 5'(hpt_pkg::MAT_ENTRIES + 1);
   localparam logic [1:0] ROW_LAST_DIV    = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_OUT
   } state_type;

   state_type         state_ff, state_in;
   hpt_pkg::word_type matrix_ff [hpt_pkg::MAT_ENTRIES];
   hpt_pkg::word_type matrix_in [hpt_pkg::MAT_ENTRIES];
   hpt_pkg::word_type vec_ff [4];
   hpt_pkg::word_type vec_in [4];
   hpt_pkg::word_type res_ff [4];
   hpt_pkg::word_type res_in [4];
   logic              point_ff, point_in;
   logic              ovf_ff, ovf_in;
   logic              zdiv_ff, zdiv_in;
   logic [4:0]        step_ff, step_in;
   logic [1:0]        row_ff, row_in;
   logic              rsp_valid_ff, rsp_valid_in;
   hpt_pkg::rsp_type  rsp_data_ff, rsp_data_in;

   hpt_pkg::mac_req_type              mac_req;
   logic signed [hpt_pkg::ACC_BITS-1:0] mac_acc;
   hpt_pkg::div_req_type              div_req;
   hpt_pkg::div_rsp_type              div_rsp;

   logic [3:0]                      k;
   logic [4:0]                      save_step;
   logic [hpt_pkg::ACC_BITS-W-F:0]  acc_hi;
   logic                            row_fits;
   hpt_pkg::word_type               row_val;

   hpt_mac u_mac (
      .clock   (clock),
      .reset   (reset),
      .mac_req (mac_req),
      .acc     (mac_acc)
   );

   hpt_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      // product k uses entry (column k[1:0], row k[3:2])
      k             = step_ff[3:0];
      mac_req.issue = (state_ff == ST_MAC) && !step_ff[4];
      mac_req.first = (k[1:0] == 2'd0);
      mac_req.a     = matrix_ff[{k[1:0], k[3:2]}];
      mac_req.b     = vec_ff[k[1:0]];

      // row sum >>> fraction, saturated to a word
      acc_hi   = mac_acc[hpt_pkg::ACC_BITS-1:W+F-1];
      row_fits = (&acc_hi) || !(|acc_hi);
      row_val  = row_fits ? mac_acc[W+F-1:F]
                          : (mac_acc[hpt_pkg::ACC_BITS-1] ? hpt_pkg::WORD_MIN
                                                          : hpt_pkg::WORD_MAX);
      save_step = step_ff - STEP_FIRST_SAVE;

      div_req.start = 1'b0;
      div_req.num   = res_ff[row_ff];
      div_req.den   = res_ff[3];

      state_in     = state_ff;
      matrix_in    = matrix_ff;
      vec_in       = vec_ff;
      res_in       = res_ff;
      point_in     = point_ff;
      ovf_in       = ovf_ff;
      zdiv_in      = zdiv_ff;
      step_in      = step_ff;
      row_in       = row_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_data.cmd) inside
                  hpt_pkg::CMD_LOAD: begin
                     matrix_in[req_data.entry_index] = req_data.entry_value;
                  end
                  hpt_pkg::CMD_VECTOR, hpt_pkg::CMD_POINT: begin
                     vec_in[0] = req_data.in_x;
                     vec_in[1] = req_data.in_y;
                     vec_in[2] = req_data.in_z;
                     vec_in[3] = (req_data.cmd == hpt_pkg::CMD_POINT) ? hpt_pkg::FIX_ONE
                                                                       : req_data.in_w;
                     point_in  = (req_data.cmd == hpt_pkg::CMD_POINT);
                     ovf_in    = 1'b0;
                     zdiv_in   = 1'b0;
                     step_in   = '0;
                     state_in  = ST_MAC;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_MAC: begin
            step_in = step_ff + 5'd1;
            if ((step_ff[1:0] == 2'd1) && (step_ff >= STEP_FIRST_SAVE)) begin
               res_in[save_step[3:2]] = row_val;
               ovf_in = ovf_ff || !row_fits;
            end
            if (step_ff == STEP_LAST) begin
               row_in   = '0;
               state_in = point_ff ? ST_DIV_START : ST_OUT;
            end
         end
         ST_DIV_START: begin
            if (res_ff[3] == '0) begin
               res_in[row_ff] = res_ff[row_ff][W-1] ? hpt_pkg::WORD_MIN
                                                    : hpt_pkg::WORD_MAX;
               zdiv_in  = 1'b1;
               row_in   = row_ff + 2'd1;
               state_in = (row_ff == ROW_LAST_DIV) ? ST_OUT : ST_DIV_START;
            end else begin
               div_req.start = 1'b1;
               state_in      = ST_DIV_WAIT;
            end
         end
         ST_DIV_WAIT: begin
            if (div_rsp.done) begin
               res_in[row_ff] = div_rsp.quotient;
               ovf_in   = ovf_ff || div_rsp.overflow;
               row_in   = row_ff + 2'd1;
               state_in = (row_ff == ROW_LAST_DIV) ? ST_OUT : ST_DIV_START;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_data_in.out_x        = res_ff[0];
               rsp_data_in.out_y        = res_ff[1];
               rsp_data_in.out_z        = res_ff[2];
               rsp_data_in.out_w        = res_ff[3];
               rsp_data_in.zero_divisor = zdiv_ff;
               rsp_data_in.overflow     = ovf_ff;
               rsp_valid_in             = 1'b1;
               state_in                 = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < hpt_pkg::MAT_ENTRIES; i++) begin
            matrix_ff[i] <= ((i >> 2) == (i & 3)) ? hpt_pkg::FIX_ONE : '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         matrix_ff    <= matrix_in;
      end
      vec_ff      <= vec_in;
      res_ff      <= res_in;
      point_ff    <= point_in;
      ovf_ff      <= ovf_in;
      zdiv_ff     <= zdiv_in;
      step_ff     <= step_in;
      row_ff      <= row_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a transform item holds off the request side while in work
   a_busy_after_transform: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall &&
       (req_data.cmd == hpt_pkg::CMD_VECTOR || req_data.cmd == hpt_pkg::CMD_POINT))
      |=> req_stall)
      else $error("transform item accepted without going busy");

   // a zero divisor result always carries a zero fourth row
   a_zdiv_means_zero_w: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.zero_divisor) |-> (rsp_data.out_w == '0))
      else $error("zero divisor flag with nonzero w");

   // divider finishes only while the sequencer waits for it
   a_div_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_DIV_WAIT))
      else $error("divider result outside wait state");

   // a new result never overwrites one still stalled
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall && state_ff == ST_OUT) |=> (state_ff == ST_OUT))
      else $error("result register overwritten while stalled");

endmodule

### rtl/core/hpt_mac.sv
// hpt_mac: shared multiply-accumulate unit, one registered product per cycle
// depends on hpt_pkg
`timescale 1ns / 1ps

module hpt_mac (
   input  logic                                  clock,
   input  logic                                  reset,
   input  hpt_pkg::mac_req_type                  mac_req,
   output logic signed [hpt_pkg::ACC_BITS-1:0]   acc
);

   logic signed [2*hpt_pkg::WORD_BITS-1:0] prod_ff, prod_in;
   logic                                   vld_ff, vld_in;
   logic                                   first_ff, first_in;
   logic signed [hpt_pkg::ACC_BITS-1:0]    acc_ff, acc_in;
   logic signed [hpt_pkg::ACC_BITS-1:0]    acc_base;

   always_comb begin
      prod_in  = $signed(mac_req.a) * $signed(mac_req.b);
      vld_in   = mac_req.issue;
      first_in = mac_req.first;
      acc_base = first_ff ? '0 : acc_ff;
      acc_in   = acc_ff;
      if (vld_ff) begin
         acc_in = acc_base + hpt_pkg::ACC_BITS'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      prod_ff  <= prod_in;
      first_ff <= first_in;
      acc_ff   <= acc_in;
   end

   assign acc = acc_ff;

endmodule

### rtl/core/hpt_div.sv
// hpt_div: restoring fixed point divider, one quotient bit per cycle,
// with sign handling and saturation; depends on hpt_pkg
`timescale 1ns / 1ps

module hpt_div (
   input  logic                 clock,
   input  logic                 reset,
   input  hpt_pkg::div_req_type div_req,
   output hpt_pkg::div_rsp_type div_rsp
);

   localparam int W = hpt_pkg::WORD_BITS;
   localparam int Q = hpt_pkg::QUO_BITS;
   localparam int F = hpt_pkg::FRACTION_BITS;
   localparam logic [Q-1:0] Q_MIN_MAG = {{(Q-W){1'b0}}, 1'b1, {(W-1){1'b0}}};

   logic [Q-1:0]                  nq_ff, nq_in;
   logic [W:0]                    rem_ff, rem_in;
   logic [W-1:0]                  ud_ff, ud_in;
   logic                          neg_ff, neg_in;
   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [hpt_pkg::QCNT_BITS-1:0] cnt_ff, cnt_in;

   logic [W-1:0] num_mag;
   logic [W-1:0] den_mag;
   logic [W:0]   rem_sh;
   logic         fits;
   logic         big;
   logic         ovf;
   logic [W-1:0] q_low;

   always_comb begin
      num_mag = div_req.num[W-1] ? (~div_req.num + 1'b1) : div_req.num;
      den_mag = div_req.den[W-1] ? (~div_req.den + 1'b1) : div_req.den;
      rem_sh  = {rem_ff[W-1:0], nq_ff[Q-1]};
      fits    = rem_sh >= {1'b0, ud_ff};

      nq_in   = nq_ff;
      rem_in  = rem_ff;
      ud_in   = ud_ff;
      neg_in  = neg_ff;
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;

      if (div_req.start) begin
         nq_in   = {num_mag, {F{1'b0}}};
         rem_in  = '0;
         ud_in   = den_mag;
         neg_in  = div_req.num[W-1] ^ div_req.den[W-1];
         busy_in = 1'b1;
         cnt_in  = '0;
      end else if (busy_ff) begin
         rem_in = fits ? (rem_sh - {1'b0, ud_ff}) : rem_sh;
         nq_in  = {nq_ff[Q-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == hpt_pkg::QCNT_BITS'(Q - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end

      // quotient after the last step
      big   = |nq_ff[Q-1:W-1];
      ovf   = neg_ff ? (big && (nq_ff != Q_MIN_MAG)) : big;
      q_low = neg_ff ? (~nq_ff[W-1:0] + 1'b1) : nq_ff[W-1:0];

      div_rsp.done     = done_ff;
      div_rsp.overflow = ovf;
      div_rsp.quotient = ovf ? (neg_ff ? hpt_pkg::WORD_MIN : hpt_pkg::WORD_MAX)
                             : hpt_pkg::word_type'(q_low);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      nq_ff  <= nq_in;
      rem_ff <= rem_in;
      ud_ff  <= ud_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
   end

endmodule

### tb/homogeneous_point_transform_tb.sv
// homogeneous_point_transform_tb: self-checking bench for the 4x4 transform
// engine; a scoreboard class predicts each vector and point result in Q16.16
// depends on hpt_pkg and homogeneous_point_transform
`timescale 1ns / 1ps

module homogeneous_point_transform_tb;

   localparam int RANDOM_ITEMS  = 750;
   localparam int HOLD_START    = 5000;
   localparam int HOLD_CYCLES   = 600;
   localparam int STEADY_START  = 15000;
   localparam int STEADY_END    = 25000;
   localparam int DRAIN_CYCLES  = 250;
   localparam int REQ_BITS      = $bits(hpt_pkg::req_type);
   localparam hpt_pkg::cmd_type CMD_NONE = 2'd3;

   class transform_scoreboard;
      hpt_pkg::word_type matrix [hpt_pkg::MAT_ENTRIES];
      hpt_pkg::rsp_type  expected_rsp [$];
      int errors, loads, vectors, points, checked, zdiv_expected, ovf_expected;

      function new();
         for (int k = 0; k < hpt_pkg::MAT_ENTRIES; k++)
            matrix[k] = (k % 5 == 0) ? hpt_pkg::FIX_ONE : '0;
      endfunction

      function hpt_pkg::word_type row_value(int r, hpt_pkg::word_type v [4],
                                            inout bit ovf);
         logic signed [hpt_pkg::ACC_BITS-1:0] acc;
         logic signed [hpt_pkg::ACC_BITS-1:0] sh;
         logic signed [2*hpt_pkg::WORD_BITS-1:0] prod;
         acc = '0;
         for (int c = 0; c < 4; c++) begin
            prod = matrix[4*c + r] * v[c];
            acc = acc + prod;
         end
         sh = acc >>> hpt_pkg::FRACTION_BITS;
         if (sh[hpt_pkg::ACC_BITS-1:hpt_pkg::WORD_BITS-1] !=
             {(hpt_pkg::ACC_BITS-hpt_pkg::WORD_BITS+1){sh[hpt_pkg::ACC_BITS-1]}}) begin
            ovf = 1'b1;
            return sh[hpt_pkg::ACC_BITS-1] ? hpt_pkg::WORD_MIN : hpt_pkg::WORD_MAX;
         end
         return sh[hpt_pkg::WORD_BITS-1:0];
      endfunction

      function hpt_pkg::word_type quotient(hpt_pkg::word_type num,
                                           hpt_pkg::word_type den, inout bit ovf);
         longint n, d;
         logic [63:0] un, ud, q, limit, nq;
         bit neg;
         n = num;
         d = den;
         un = (n < 0) ? -n : n;
         ud = (d < 0) ? -d : d;
         neg = (n < 0) != (d < 0);
         q = (un << hpt_pkg::FRACTION_BITS) / ud;
         limit = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
         if (q > limit) begin
            ovf = 1'b1;
            return neg ? hpt_pkg::WORD_MIN : hpt_pkg::WORD_MAX;
         end
         nq = neg ? -q : q;
         return nq[hpt_pkg::WORD_BITS-1:0];
      endfunction

      function void note_request(hpt_pkg::req_type it);
         hpt_pkg::word_type v [4];
         hpt_pkg::word_type res [4];
         bit ovf, zdiv;
         hpt_pkg::rsp_type e;
         ovf = 1'b0;
         zdiv = 1'b0;
         case (it.cmd) inside
            hpt_pkg::CMD_LOAD: begin
               matrix[it.entry_index] = it.entry_value;
               loads++;
            end
            hpt_pkg::CMD_VECTOR, hpt_pkg::CMD_POINT: begin
               v[0] = it.in_x;
               v[1] = it.in_y;
               v[2] = it.in_z;
               v[3] = (it.cmd == hpt_pkg::CMD_POINT) ? hpt_pkg::FIX_ONE : it.in_w;
               for (int r = 0; r < 4; r++)
                  res[r] = row_value(r, v, ovf);
               if (it.cmd == hpt_pkg::CMD_POINT) begin
                  points++;
                  for (int r = 0; r < 3; r++) begin
                     if (res[3] == 0) begin
                        zdiv = 1'b1;
                        res[r] = (res[r] < 0) ? hpt_pkg::WORD_MIN : hpt_pkg::WORD_MAX;
                     end else begin
                        res[r] = quotient(res[r], res[3], ovf);
                     end
                  end
               end else begin
                  vectors++;
               end
               e.out_x = res[0];
               e.out_y = res[1];
               e.out_z = res[2];
               e.out_w = res[3];
               e.zero_divisor = zdiv;
               e.overflow = ovf;
               zdiv_expected += zdiv;
               ovf_expected += ovf;
               expected_rsp.insert(expected_rsp.size(), e);
            end
            default: ;
         endcase
      endfunction

      function void compare_field(string name, logic [hpt_pkg::WORD_BITS-1:0] want,
                                  logic [hpt_pkg::WORD_BITS-1:0] got);
         if (want !== got) begin
            $error("%s mismatch: expected %h, actual %h", name, want, got);
            errors++;
         end
      endfunction

      function void check_result(hpt_pkg::rsp_type got);
         hpt_pkg::rsp_type want;
         if (expected_rsp.size() == 0) begin
            $error("result with no item pending: %p", got);
            errors++;
            return;
         end
         want = expected_rsp.pop_front();
         checked++;
         compare_field("out_x", want.out_x, got.out_x);
         compare_field("out_y", want.out_y, got.out_y);
         compare_field("out_z", want.out_z, got.out_z);
         compare_field("out_w", want.out_w, got.out_w);
         compare_field("zero_divisor", hpt_pkg::WORD_BITS'(want.zero_divisor),
                       hpt_pkg::WORD_BITS'(got.zero_divisor));
         compare_field("overflow", hpt_pkg::WORD_BITS'(want.overflow),
                       hpt_pkg::WORD_BITS'(got.overflow));
      endfunction

      function int pending();
         return expected_rsp.size();
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   hpt_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   hpt_pkg::rsp_type rsp_data;

   transform_scoreboard sb;
   int  stall_cycle;
   int  random_sent;
   bit  steady_sender;

   homogeneous_point_transform dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #12_000_000;
      $display("Test completed with failures");
      $finish;
   end

   function automatic hpt_pkg::word_type rand_word();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 45)
         return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
      else if (pick < 60)
         return $signed($urandom_range(0, 512)) - 256;
      else if (pick < 75)
         return $urandom;
      else if (pick < 90) begin
         case ($urandom_range(0, 6))
            0: return hpt_pkg::WORD_MAX;
            1: return hpt_pkg::WORD_MIN;
            2: return '0;
            3: return hpt_pkg::FIX_ONE;
            4: return -hpt_pkg::FIX_ONE;
            5: return 1;
            default: return -1;
         endcase
      end
      return $signed($urandom_range(0, 1 << 25)) - (1 << 24);
   endfunction

   function automatic hpt_pkg::req_type load_req(int idx, hpt_pkg::word_type value);
      hpt_pkg::req_type it;
      it = REQ_BITS'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
      it.cmd = hpt_pkg::CMD_LOAD;
      it.entry_index = idx[hpt_pkg::MAT_IDX_BITS-1:0];
      it.entry_value = value;
      return it;
   endfunction

   function automatic hpt_pkg::req_type xform_req(hpt_pkg::cmd_type cmd,
                                                  hpt_pkg::word_type x,
                                                  hpt_pkg::word_type y,
                                                  hpt_pkg::word_type z,
                                                  hpt_pkg::word_type w);
      hpt_pkg::req_type it;
      it = REQ_BITS'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
      it.cmd = cmd;
      it.in_x = x;
      it.in_y = y;
      it.in_z = z;
      it.in_w = w;
      return it;
   endfunction

   task automatic offer_item(input hpt_pkg::req_type it);
      bit taken;
      req_valid <= 1'b1;
      req_data <= it;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
      sb.note_request(it);
   endtask

   task automatic send(input hpt_pkg::req_type it);
      if (!steady_sender) begin
         while ($urandom_range(0, 99) < 21) begin
            req_valid <= 1'b0;
            req_data <= REQ_BITS'({$urandom, $urandom, $urandom, $urandom,
                                   $urandom, $urandom});
            @(posedge clock);
         end
      end
      offer_item(it);
   endtask

   task automatic run_directed();
      // identity passes vectors and points through unchanged
      send(xform_req(hpt_pkg::CMD_VECTOR, 3 * hpt_pkg::FIX_ONE, -5 * hpt_pkg::FIX_ONE,
                     7, -hpt_pkg::FIX_ONE));
      send(xform_req(hpt_pkg::CMD_POINT, hpt_pkg::WORD_MAX, hpt_pkg::WORD_MIN, '0,
                     $urandom));
      send(xform_req(hpt_pkg::CMD_VECTOR, hpt_pkg::WORD_MIN, hpt_pkg::WORD_MIN,
                     hpt_pkg::WORD_MIN, hpt_pkg::WORD_MIN));
      send(xform_req(hpt_pkg::CMD_VECTOR, hpt_pkg::WORD_MAX, hpt_pkg::WORD_MAX,
                     hpt_pkg::WORD_MAX, hpt_pkg::WORD_MAX));
      send(xform_req(CMD_NONE, $urandom, $urandom, $urandom, $urandom));
      // row saturation both ways
      send(load_req(0, hpt_pkg::WORD_MAX));
      send(xform_req(hpt_pkg::CMD_VECTOR, hpt_pkg::WORD_MAX, 0, 0, 0));
      send(load_req(0, hpt_pkg::WORD_MIN));
      send(xform_req(hpt_pkg::CMD_VECTOR, hpt_pkg::WORD_MIN, 1, 2, 3));
      send(xform_req(hpt_pkg::CMD_POINT, hpt_pkg::WORD_MAX, -hpt_pkg::FIX_ONE,
                     hpt_pkg::FIX_ONE, 0));
      // shift rounds toward minus infinity
      send(load_req(0, 1));
      send(xform_req(hpt_pkg::CMD_VECTOR, -1, -1, 1, 0));
      send(load_req(0, hpt_pkg::FIX_ONE));
      // zero divisor, dividends of each sign
      send(load_req(15, '0));
      send(xform_req(hpt_pkg::CMD_POINT, 2 * hpt_pkg::FIX_ONE, -3 * hpt_pkg::FIX_ONE,
                     '0, hpt_pkg::FIX_ONE));
      send(xform_req(hpt_pkg::CMD_VECTOR, hpt_pkg::FIX_ONE, hpt_pkg::FIX_ONE,
                     hpt_pkg::FIX_ONE, hpt_pkg::FIX_ONE));
      // tiny divisor makes quotients overflow
      send(load_req(15, 1));
      send(xform_req(hpt_pkg::CMD_POINT, 2 * hpt_pkg::FIX_ONE, -2 * hpt_pkg::FIX_ONE,
                     1, hpt_pkg::WORD_MIN));
      // negative divisor, truncation toward zero and the most negative dividend
      send(load_req(15, -2 * hpt_pkg::FIX_ONE));
      send(xform_req(hpt_pkg::CMD_POINT, 3, -3, hpt_pkg::WORD_MIN, 0));
      send(load_req(15, -hpt_pkg::FIX_ONE));
      send(xform_req(hpt_pkg::CMD_POINT, hpt_pkg::WORD_MIN, hpt_pkg::WORD_MAX,
                     hpt_pkg::FIX_ONE, 0));
      send(load_req(15, hpt_pkg::FIX_ONE));
   endtask

   task automatic run_random();
      int unsigned pick;
      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         steady_sender = (random_sent >= 300 && random_sent < 450);
         if ($urandom_range(0, 99) < 8) begin
            for (int k = 0; k < hpt_pkg::MAT_ENTRIES; k++)
               send(load_req(k, rand_word()));
            random_sent += hpt_pkg::MAT_ENTRIES;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 18)
               send(load_req($urandom_range(0, hpt_pkg::MAT_ENTRIES - 1), rand_word()));
            else if (pick < 55)
               send(xform_req(hpt_pkg::CMD_VECTOR, rand_word(), rand_word(),
                              rand_word(), rand_word()));
            else if (pick < 93)
               send(xform_req(hpt_pkg::CMD_POINT, rand_word(), rand_word(),
                              rand_word(), rand_word()));
            else
               send(xform_req(CMD_NONE, $urandom, $urandom, $urandom, $urandom));
            if (pick < 93)
               random_sent++;
         end
      end
      steady_sender = 1'b0;
   endtask

   // result side: random stalls, one long hold-off and one stall-free stretch
   initial begin
      rsp_stall <= 1'b0;
      stall_cycle = 0;
      forever begin
         @(posedge clock);
         stall_cycle++;
         if (stall_cycle >= HOLD_START && stall_cycle < HOLD_START + HOLD_CYCLES)
            rsp_stall <= 1'b1;
         else if (stall_cycle >= STEADY_START && stall_cycle < STEADY_END)
            rsp_stall <= 1'b0;
         else
            rsp_stall <= ($urandom_range(0, 99) < 21);
      end
   end

   always @(negedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_data);
   end

   initial begin
      sb = new();
      steady_sender = 1'b0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      run_random();
      req_valid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("ran %0d loads, %0d vector and %0d point items; %0d results checked",
               sb.loads, sb.vectors, sb.points, sb.checked);
      $display("results with zero divisor: %0d, with saturation: %0d, errors: %0d",
               sb.zdiv_expected, sb.ovf_expected, sb.errors);
      if (sb.errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
